>>> src/f2h_pkg.sv
// ----------------------------------------------------------------------------
// f2h_pkg: shared types, mode codes and conversion functions
// Holds the binary32/binary16 narrowing, widening and truncation logic.
// ----------------------------------------------------------------------------
package f2h_pkg;

    localparam logic [1:0] MODE_TO_HALF   = 2'd0;
    localparam logic [1:0] MODE_TO_SINGLE = 2'd1;
    localparam logic [1:0] MODE_ROUND     = 2'd2;
    localparam logic [1:0] MODE_TRUNC     = 2'd3;

    localparam logic [15:0] HALF_QNAN = 16'h7e00;
    localparam logic [15:0] HALF_INF  = 16'h7c00;

    typedef logic [31:0] word_t;
    typedef logic [15:0] half_t;

    function automatic half_t narrow_to_half(input word_t bits);
        logic [15:0] sgn;
        logic [7:0]  expo;
        logic [22:0] mant;
        logic [23:0] full;
        logic [24:0] sum;
        logic [4:0]  sh;
        logic [23:0] r;
        half_t       res;
        sgn  = {bits[31], 15'd0};
        expo = bits[30:23];
        mant = bits[22:0];
        full = {1'b1, mant};
        sh   = 5'd0;
        sum  = '0;
        r    = '0;
        if (expo == 8'hff) begin
            res = sgn | ((mant != '0) ? HALF_QNAN : HALF_INF);
        end
        else if (expo >= 8'd143) begin
            res = sgn | HALF_INF;
        end
        else if (expo <= 8'd112) begin
            if (expo < 8'd102) begin
                res = sgn;
            end
            else begin
                // shift of 14 - (expo - 112) = 126 - expo, 14..24
                sh  = 5'(8'd126 - expo);
                sum = {1'b0, full} + (25'd1 << (sh - 5'd1));
                res = sgn | 16'(sum >> sh);
            end
        end
        else begin
            r = {1'b0, mant} + 24'h1000;
            if (r[23]) begin
                if (expo == 8'd142)
                    res = sgn | HALF_INF;
                else
                    res = sgn | {1'b0, 5'(expo - 8'd111), 10'd0};
            end
            else begin
                res = sgn | {1'b0, 5'(expo - 8'd112), r[22:13]};
            end
        end
        return res;
    endfunction

    function automatic word_t widen_to_single(input half_t h);
        logic [4:0] expo;
        logic [9:0] mant;
        logic [3:0] lz;
        logic [9:0] norm;
        word_t      res;
        expo = h[14:10];
        mant = h[9:0];
        lz   = 4'd0;
        // leading-zero count over the 10-bit subnormal mantissa
        for (int i = 0; i < 10; i++) begin
            if (mant[i])
                lz = 4'(9 - i);
        end
        norm = 10'(mant << (lz + 4'd1));
        if (expo == 5'd0) begin
            if (mant == '0)
                res = {h[15], 31'd0};
            else
                res = {h[15], 8'(8'd112 - {4'd0, lz}), norm, 13'd0};
        end
        else if (expo == 5'd31) begin
            res = {h[15], 8'hff, mant, 13'd0};
        end
        else begin
            res = {h[15], 8'({3'd0, expo} + 8'd112), mant, 13'd0};
        end
        return res;
    endfunction

    function automatic word_t truncate_to_int(input word_t bits);
        logic [7:0]  expo;
        logic [4:0]  fb;
        word_t       res;
        expo = bits[30:23];
        fb   = 5'(8'd150 - expo);
        if (expo == 8'hff && bits[22:0] != '0)
            res = '0;
        else if (expo >= 8'd158)
            res = bits[31] ? 32'hcf000000 : 32'h4f000000;
        else if (expo < 8'd127)
            res = '0;
        else if (expo >= 8'd150)
            res = bits;
        else
            res = bits & ~((32'd1 << fb) - 32'd1);
        return res;
    endfunction

endpackage

>>> src/fp32_fp16_store_rounding.sv
// Each accepted item is captured in the input register, then in the result register that drives result_bits.
// Throughput: one item per cycle while out_stall is low; the conversion is one combinational pass.
// Result register stalls propagate back through the input stage.
// Reset clears the valid flags only; no clearing pass.
// ----------------------------------------------------------------------------
// fp32_fp16_store_rounding: binary32/binary16 converter
// Narrows, widens, rounds through half, or truncates to integer per req_type.
// ----------------------------------------------------------------------------
module fp32_fp16_store_rounding
    import f2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits
);

    logic        s1_valid_reg;
    logic [1:0]  s1_type_reg;
    word_t       s1_value_reg;
    logic        s2_valid_reg;
    word_t       s2_result_reg;
    word_t       result_next;
    logic        s2_load;
    logic        s1_load;

    assign s2_load  = !s2_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    always_comb
    begin
        case (s1_type_reg)
            MODE_TO_HALF:   result_next = {16'd0, narrow_to_half(s1_value_reg)};
            MODE_TO_SINGLE: result_next = widen_to_single(s1_value_reg[15:0]);
            MODE_ROUND:     result_next = widen_to_single(narrow_to_half(s1_value_reg));
            default:        result_next = truncate_to_int(s1_value_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_type_reg  <= req_type;
            s1_value_reg <= value_bits;
        end
        if (s2_load && s1_valid_reg)
            s2_result_reg <= result_next;
    end

    assign out_valid   = s2_valid_reg;
    assign result_bits = s2_result_reg;

`ifndef SYNTH
    // hold the result while the consumer stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_bits))
        else $error("result changed under stall");
    // a full pipe with a stalled output must stall the input
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && out_stall |-> in_stall)
        else $error("input taken with full pipe");
    // an accepted item reaches the result stage when it is free
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_load |=> s2_valid_reg)
        else $error("item lost between stages");
`endif

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression for the binary32/binary16 converter
// Drives conversion requests in all four modes, predicts each result from a
// bit-level model of the conversions, and checks results in order.
// ----------------------------------------------------------------------------
module tb_top
    import f2h_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [31:0] value_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_bits;

    word_t expected_q[$];
    int    n_errors;
    int    n_checked;
    int    n_sent;
    bit    rx_hold;      // long receiver hold-off request
    bit    rx_random;    // random receiver stalls enabled

    fp32_fp16_store_rounding u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .value_bits  (value_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_bits (result_bits)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: bit-level conversions
    // ------------------------------------------------------------------
    function automatic logic [15:0] to_half(input logic [31:0] b);
        logic [15:0] s;
        logic [7:0]  e;
        logic [22:0] m;
        int          he;
        int          sh;
        logic [31:0] acc;
        s  = {b[31], 15'd0};
        e  = b[30:23];
        m  = b[22:0];
        he = int'(e) - 112;
        if (e == 8'hff)
            return s | ((m != 0) ? 16'h7e00 : 16'h7c00);
        if (he >= 31)
            return s | 16'h7c00;
        if (he <= 0)
        begin
            if (he < -10)
                return s;
            sh  = 14 - he;
            acc = ({9'd0, m} | 32'h800000) + (32'd1 << (sh - 1));
            return s | 16'(acc >> sh);
        end
        acc = {9'd0, m} + 32'h1000;
        if (acc[23])
        begin
            if (he + 1 >= 31)
                return s | 16'h7c00;
            return s | 16'((he + 1) << 10);
        end
        return s | 16'(he << 10) | 16'(acc >> 13);
    endfunction

    function automatic logic [31:0] to_single(input logic [15:0] h);
        logic [31:0] s;
        logic [4:0]  e;
        logic [31:0] m;
        int          sh;
        s  = {h[15], 31'd0};
        e  = h[14:10];
        m  = {22'd0, h[9:0]};
        sh = 0;
        if (e == 0)
        begin
            if (m == 0)
                return s;
            while (m[10] == 1'b0 && sh < 11)
            begin
                m  = m << 1;
                sh = sh + 1;
            end
            m = m & 32'h3ff;
            return s | (32'(113 - sh) << 23) | (m << 13);
        end
        if (e == 5'd31)
            return s | 32'h7f800000 | (m << 13);
        return s | (32'(e + 112) << 23) | (m << 13);
    endfunction

    function automatic logic [31:0] trunc_int(input logic [31:0] b);
        logic [7:0] e;
        e = b[30:23];
        if (e == 8'hff && b[22:0] != 0)
            return 32'd0;
        if (e >= 158)
            return b[31] ? 32'hcf000000 : 32'h4f000000;
        if (e < 127)
            return 32'd0;
        if (e >= 150)
            return b;
        return b & ~((32'd1 << (150 - e)) - 32'd1);
    endfunction

    function automatic logic [31:0] convert(input logic [1:0] mode, input logic [31:0] v);
        case (mode)
            MODE_TO_HALF:   return {16'd0, to_half(v)};
            MODE_TO_SINGLE: return to_single(v[15:0]);
            MODE_ROUND:     return to_single(to_half(v));
            default:        return trunc_int(v);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // drop valid only for a real gap so back-to-back transfers keep it high
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_conv(input logic [1:0] mode, input logic [31:0] v, input bit gaps);
        if (gaps)
            idle_gap();
        in_valid   <= 1'b1;
        req_type   <= mode;
        value_bits <= v;
        expected_q = {expected_q, convert(mode, v)};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report("unexpected result", result_bits, 32'd0);
            else
            begin
                if (result_bits !== expected_q[0])
                    report("result_bits", result_bits, expected_q[0]);
                void'(expected_q.pop_front());
                n_checked++;
            end
        end
    end

    // Receiver stalls; a hold request forces a long stretch.
    always @(negedge clk)
    begin
        if (rx_hold)
            out_stall <= 1'b1;
        else if (rx_random)
            out_stall <= ($urandom_range(0, 9) < 3);
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [31:0] vals[$];
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0001, 32'hffff_ffff, 32'h477f_f000, 32'h477f_efff,
                 32'h3380_0000, 32'h32ff_ffff, 32'h387f_f000, 32'h3f80_1000,
                 32'h4f00_0000, 32'hcf00_0001, 32'hbf7f_ffff, 32'h4b7f_ffff,
                 32'hc0b0_0000, 32'h0000_0001, 32'h0000_fc01, 32'hffff_0200,
                 32'h1234_03ff, 32'h0000_7bff};
        foreach (vals[i])
            for (int m = 0; m < 4; m++)
                send_conv(2'(m), vals[i], 1'b0);
        drain();
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'($urandom_range(100, 145));   // around the half range
            1: v[30:23] = 8'($urandom_range(120, 160));   // around integer range
            2: v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            3: v[12:0]  = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;  // rounding edge
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_random(input int count);
        rx_random = 1'b1;
        repeat (count)
            send_conv(2'($urandom_range(0, 3)), rand_value(), 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (60) @(negedge clk);
                rx_hold = 1'b0;
            end
            repeat (40)
                send_conv(2'($urandom_range(0, 3)), rand_value(), 1'b0);
        join
        drain();
        // back-to-back burst with no stalls, then pause until all arrive
        rx_random = 1'b0;
        repeat (100)
            send_conv(2'($urandom_range(0, 3)), rand_value(), 1'b0);
        drain();
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = MODE_TO_HALF;
        value_bits = '0;
        out_stall  = 1'b0;
        rx_hold    = 1'b0;
        rx_random  = 1'b0;
        n_errors   = 0;
        n_checked  = 0;
        n_sent     = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(860);
        test_backpressure();
        test_random(860);

        if (expected_q.size() != 0)
        begin
            $display("%0d results never arrived", expected_q.size());
            n_errors++;
        end
        $display("Covered all four conversion modes: %0d transfers in, %0d results checked,",
                 n_sent, n_checked);
        $display("with random gaps, receiver stalls and a long receiver hold-off.");
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
